FILE: hw/rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the binomial-mod-prime block: word formats,
// the prime, its folding constant and the Fermat exponent.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

   localparam int VAL_W     = 20;   // residue width
   localparam int IDX_W     = 16;   // query field width
   localparam int EXT_W     = 17;   // index counter, can reach 65536
   localparam int PROD_W    = 2 * VAL_W;
   localparam int FOLD_W    = 16;

   localparam logic [VAL_W-1:0]  PRIME  = 20'd1000003;
   // 2^20 - PRIME, so hi*2^20 + lo folds to hi*FOLD_C + lo
   localparam logic [FOLD_W-1:0] FOLD_C = 16'd48573;
   localparam logic [VAL_W-1:0]  EXPO   = 20'd1000001;
   localparam int EXP_BITS  = VAL_W;
   localparam int EXP_CNT_W = $clog2(EXP_BITS);

   localparam int TABLE_DEPTH_DEF = 65536;

   typedef struct packed {
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] k;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             bad_query;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } mm_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] value;
   } mm_rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bmp_mulmod.sv
// ----------------------------------------------------------------------------
// bmp_mulmod
// Multi-cycle modular multiplier: one 20x20 product, then folds of the upper
// bits through 2^20 = FOLD_C (mod p) until the word fits 20 bits, then one
// conditional subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_mulmod (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bmp_pkg::mm_req_type mm_req,
   output bmp_pkg::mm_rsp_type      mm_rsp
);
   import bmp_pkg::*;

   logic                      busy_ff;
   logic [PROD_W-1:0]         x_ff;
   logic                      done_ff;
   logic [VAL_W-1:0]          value_ff;

   logic [PROD_W-1:0]         prod;
   logic [VAL_W-1:0]          hi;
   logic [VAL_W-1:0]          lo;
   logic [VAL_W+FOLD_W-1:0]   fold_prod;
   logic [PROD_W-1:0]         fold_in;
   logic [VAL_W-1:0]          final_val;

   assign prod      = {{VAL_W{1'b0}}, mm_req.a} * {{VAL_W{1'b0}}, mm_req.b};
   assign hi        = x_ff[PROD_W-1:VAL_W];
   assign lo        = x_ff[VAL_W-1:0];
   assign fold_prod = (VAL_W+FOLD_W)'(hi) * (VAL_W+FOLD_W)'(FOLD_C);
   assign fold_in   = PROD_W'(fold_prod) + PROD_W'(lo);
   // lo is below 2^20 < 2p here, one subtract is enough
   assign final_val = (lo >= PRIME) ? (lo - PRIME) : lo;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (mm_req.start) begin
         x_ff    <= prod;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (hi != '0) begin
            x_ff <= fold_in;
         end else begin
            value_ff <= final_val;
            done_ff  <= 1'b1;
            busy_ff  <= 1'b0;
         end
      end
   end

   assign mm_rsp.done  = done_ff;
   assign mm_rsp.value = value_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bmp_ctrl.sv
// ----------------------------------------------------------------------------
// bmp_ctrl
// Query sequencer with the factorial memory: extends the table on demand,
// looks up n!, (n-k)! and k!, then runs the Fermat inverse by
// square-and-multiply on the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_ctrl #(
   parameter int TABLE_DEPTH = bmp_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                qry_valid,
   input  wire bmp_pkg::req_type    qry,
   output logic                     qry_take,
   output logic                     res_valid,
   output bmp_pkg::rsp_type         res,
   input  wire logic                res_ready,
   output bmp_pkg::mm_req_type      mm_req,
   input  wire bmp_pkg::mm_rsp_type mm_rsp
);
   import bmp_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = (AW > IDX_W) ? AW : IDX_W;
   localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILL, ST_LOOK, ST_LOOK_MEM, ST_LOOK_DATA, ST_EXT,
      ST_DEN, ST_POW, ST_POW_SQ, ST_FIN, ST_MWAIT, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_FILL, OP_EXT, OP_DEN, OP_POW_MUL, OP_POW_SQ, OP_FIN
   } op_type;

   typedef enum logic [1:0] {
      SEL_N, SEL_NK, SEL_K
   } sel_type;

   state_type             state_ff;
   op_type                op_ff;
   sel_type               sel_ff;
   logic [IDX_W-1:0]      n_ff;
   logic [IDX_W-1:0]      k_ff;
   logic [IDX_W-1:0]      m_ff;
   logic [AW-1:0]         target_ff;
   logic [AW-1:0]         filled_ff;
   logic [AW-1:0]         top_ff;
   logic [EXT_W-1:0]      i_ff;
   logic [VAL_W-1:0]      last_ff;
   logic [VAL_W-1:0]      f_ff;
   logic [VAL_W-1:0]      fn_ff;
   logic [VAL_W-1:0]      fnk_ff;
   logic [VAL_W-1:0]      fk_ff;
   logic [VAL_W-1:0]      base_ff;
   logic [VAL_W-1:0]      acc_ff;
   logic [EXP_CNT_W-1:0]  bit_ff;
   mm_req_type            mm_req_ff;
   rsp_type               res_ff;

   logic                  wr_en_ff;
   logic [AW-1:0]         wr_addr_ff;
   logic [VAL_W-1:0]      wr_data_ff;
   logic [AW-1:0]         rd_addr_ff;
   logic [VAL_W-1:0]      rd_data_ff;
   logic [VAL_W-1:0]      fact_mem [TABLE_DEPTH];

   logic [IDX_W-1:0]      m_cur;

   function automatic logic [AW-1:0] clip_idx(input logic [IDX_W-1:0] m);
      logic [CW-1:0] m_ext;
      m_ext = CW'(m);
      if (m_ext > LAST_IDX)
         return LAST_IDX[AW-1:0];
      else
         return m_ext[AW-1:0];
   endfunction

   always_comb begin
      unique case (sel_ff)
         SEL_N:   m_cur = n_ff;
         SEL_NK:  m_cur = n_ff - k_ff;
         SEL_K:   m_cur = k_ff;
         default: m_cur = n_ff;
      endcase
   end

   // Writes only happen during fill and reads only after it, so a read never
   // meets a write to the same entry in flight.
   always_ff @(posedge clock) begin
      if (wr_en_ff)
         fact_mem[wr_addr_ff] <= wr_data_ff;
      rd_data_ff <= fact_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      mm_req_ff.start <= 1'b0;
      wr_en_ff        <= 1'b0;
      if (reset) begin
         state_ff  <= ST_IDLE;
         filled_ff <= AW'(1);
         last_ff   <= VAL_W'(1);
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (qry_valid) begin
                  n_ff <= qry.n;
                  k_ff <= qry.k;
                  if (qry.k > qry.n) begin
                     res_ff.value     <= '0;
                     res_ff.bad_query <= 1'b1;
                     state_ff         <= ST_DONE;
                  end else begin
                     target_ff <= clip_idx(qry.n);
                     state_ff  <= ST_FILL;
                  end
               end
            end
            ST_FILL: begin
               if (filled_ff < target_ff) begin
                  mm_req_ff.start <= 1'b1;
                  mm_req_ff.a     <= last_ff;
                  mm_req_ff.b     <= VAL_W'(filled_ff) + VAL_W'(1);
                  op_ff           <= OP_FILL;
                  state_ff        <= ST_MWAIT;
               end else begin
                  sel_ff   <= SEL_N;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               m_ff       <= m_cur;
               top_ff     <= clip_idx(m_cur);
               rd_addr_ff <= clip_idx(m_cur);
               state_ff   <= ST_LOOK_MEM;
            end
            ST_LOOK_MEM: begin
               state_ff <= ST_LOOK_DATA;
            end
            ST_LOOK_DATA: begin
               // entries 0 and 1 are never stored, they read as one
               f_ff     <= (32'(top_ff) < 32'd2) ? VAL_W'(1) : rd_data_ff;
               i_ff     <= EXT_W'(top_ff) + EXT_W'(1);
               state_ff <= ST_EXT;
            end
            ST_EXT: begin
               // carry on past the last table entry without storing
               if (i_ff <= EXT_W'(m_ff)) begin
                  mm_req_ff.start <= 1'b1;
                  mm_req_ff.a     <= f_ff;
                  mm_req_ff.b     <= VAL_W'(i_ff);
                  op_ff           <= OP_EXT;
                  state_ff        <= ST_MWAIT;
               end else begin
                  unique case (sel_ff)
                     SEL_N: begin
                        fn_ff    <= f_ff;
                        sel_ff   <= SEL_NK;
                        state_ff <= ST_LOOK;
                     end
                     SEL_NK: begin
                        fnk_ff   <= f_ff;
                        sel_ff   <= SEL_K;
                        state_ff <= ST_LOOK;
                     end
                     default: begin
                        fk_ff    <= f_ff;
                        state_ff <= ST_DEN;
                     end
                  endcase
               end
            end
            ST_DEN: begin
               mm_req_ff.start <= 1'b1;
               mm_req_ff.a     <= fnk_ff;
               mm_req_ff.b     <= fk_ff;
               op_ff           <= OP_DEN;
               state_ff        <= ST_MWAIT;
            end
            ST_POW: begin
               if (EXPO[bit_ff]) begin
                  mm_req_ff.start <= 1'b1;
                  mm_req_ff.a     <= acc_ff;
                  mm_req_ff.b     <= base_ff;
                  op_ff           <= OP_POW_MUL;
                  state_ff        <= ST_MWAIT;
               end else begin
                  state_ff <= ST_POW_SQ;
               end
            end
            ST_POW_SQ: begin
               // skip the square after the top exponent bit
               if (bit_ff == EXP_CNT_W'(EXP_BITS - 1)) begin
                  state_ff <= ST_FIN;
               end else begin
                  mm_req_ff.start <= 1'b1;
                  mm_req_ff.a     <= base_ff;
                  mm_req_ff.b     <= base_ff;
                  op_ff           <= OP_POW_SQ;
                  state_ff        <= ST_MWAIT;
               end
            end
            ST_FIN: begin
               mm_req_ff.start <= 1'b1;
               mm_req_ff.a     <= fn_ff;
               mm_req_ff.b     <= acc_ff;
               op_ff           <= OP_FIN;
               state_ff        <= ST_MWAIT;
            end
            ST_MWAIT: begin
               if (mm_rsp.done) begin
                  unique case (op_ff)
                     OP_FILL: begin
                        wr_en_ff   <= 1'b1;
                        wr_addr_ff <= filled_ff + AW'(1);
                        wr_data_ff <= mm_rsp.value;
                        last_ff    <= mm_rsp.value;
                        filled_ff  <= filled_ff + AW'(1);
                        state_ff   <= ST_FILL;
                     end
                     OP_EXT: begin
                        f_ff     <= mm_rsp.value;
                        i_ff     <= i_ff + EXT_W'(1);
                        state_ff <= ST_EXT;
                     end
                     OP_DEN: begin
                        base_ff  <= mm_rsp.value;
                        acc_ff   <= VAL_W'(1);
                        bit_ff   <= '0;
                        state_ff <= ST_POW;
                     end
                     OP_POW_MUL: begin
                        acc_ff   <= mm_rsp.value;
                        state_ff <= ST_POW_SQ;
                     end
                     OP_POW_SQ: begin
                        base_ff  <= mm_rsp.value;
                        bit_ff   <= bit_ff + EXP_CNT_W'(1);
                        state_ff <= ST_POW;
                     end
                     OP_FIN: begin
                        res_ff.value     <= mm_rsp.value;
                        res_ff.bad_query <= 1'b0;
                        state_ff         <= ST_DONE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_DONE: begin
               if (res_ready)
                  state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign qry_take  = (state_ff == ST_IDLE) && qry_valid;
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;
   assign mm_req    = mm_req_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/binomial_mod_prime_top.sv
// A query costs 29 modular multiplies, each with as many folds as its product
// needs, plus three table lookups, plus one multiply per new table entry.
// Throughput: one query at a time; the next is taken while a result waits.
// Reset clears control only; the factorial memory needs no clearing pass.
// ----------------------------------------------------------------------------
// binomial_mod_prime_top
// C(n,k) mod 1000003 from a memoized factorial table and a Fermat inverse,
// with a request holding register and a result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_mod_prime_top #(
   parameter int TABLE_DEPTH = bmp_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bmp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bmp_pkg::rsp_type      rsp_data
);
   import bmp_pkg::*;

   logic        q_valid_ff;
   req_type     q_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        qry_take;
   logic        res_valid;
   rsp_type     res;
   logic        out_free;
   mm_req_type  mm_req;
   mm_rsp_type  mm_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = q_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         q_valid_ff <= 1'b1;
      end else if (qry_take) begin
         q_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall)
         q_ff <= req_data;
   end

   // hold the result word until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
      if (out_free && res_valid)
         rsp_data_ff <= res;
   end

   bmp_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .qry_valid (q_valid_ff),
      .qry       (q_ff),
      .qry_take  (qry_take),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (out_free),
      .mm_req    (mm_req),
      .mm_rsp    (mm_rsp)
   );

   bmp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bmp_checker.sv
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks for the binomial-mod-prime block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bmp_pkg::rsp_type rsp_data
);
   import bmp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_query |-> rsp_data.value == '0)
      else $error("bad query with nonzero value");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.value < PRIME)
      else $error("result not reduced mod p");

   a_one_query: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second query taken while one is held");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind binomial_mod_prime_top bmp_checker u_checker (.*);

`default_nettype wire
